// ===== hw/rtl/rolling_fuel_consumption_macros.svh =====
// Assertion macros for the rolling fuel consumption block.
`ifndef ROLLING_FUEL_CONSUMPTION_MACROS_SVH
`define ROLLING_FUEL_CONSUMPTION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/rfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rfc_pkg;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned FuelW = 24;
  localparam int unsigned TimeW = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned TripW = 48;
  localparam int unsigned ConsW = 32;
  localparam int unsigned OdoW = 40;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 40;
  localparam logic [CfgIdxW-1:0] RegOdometer = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinSpeed = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFuelFloor = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDistFloor = 2'd3;
  localparam int unsigned RefreshPeriod = 20;
endpackage
`default_nettype wire

// ===== hw/rtl/rfc_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfc_divider #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] num_q, num_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  assign trial = {rem_q[DenW-1:0], num_q[NumW-1]};
  assign diff = trial - {1'b0, den_q};

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DenW]) begin
        rem_d = diff;
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o = num_d;
endmodule
`default_nettype wire

// ===== hw/rtl/rolling_fuel_consumption.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Signals
// in      | input     | in_valid_i / in_ready_o, speed, fuel_level, tick_time_ms, tick_count
// out     | output    | out_valid_o / out_ready_i, trip_distance .. odometer_total
// cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i
// A tick runs from its input transfer to the next possible one through a
// bit-serial shift-add for time*speed, then three restoring divisions on one
// shared divider (by 1000, by the distance sum, by the fill count) with a
// set-up state between them. The result is registered after the last division
// and held until taken while the next tick is accepted;
// a result still waiting holds the following tick and in_ready_o low.
// Reset clears the window stores, sums and held average at once.
module rolling_fuel_consumption
  import rfc_pkg::*;
#(
  parameter int unsigned SUM_WINDOW = 25,
  parameter int unsigned MEAN_WINDOW = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SpeedW-1:0]   speed_i,
  input  wire logic [FuelW-1:0]    fuel_level_i,
  input  wire logic [TimeW-1:0]    tick_time_ms_i,
  input  wire logic [CountW-1:0]   tick_count_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [TripW-1:0]         trip_distance_o,
  output logic [ConsW-1:0]         consumption_now_o,
  output logic [ConsW-1:0]         consumption_average_o,
  output logic [OdoW-1:0]          odometer_total_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
`include "rolling_fuel_consumption_macros.svh"
  localparam int unsigned SumIdxW = $clog2(SUM_WINDOW);
  localparam int unsigned MeanIdxW = $clog2(MEAN_WINDOW);
  localparam int unsigned FillW = $clog2(MEAN_WINDOW + 1);
  localparam int unsigned BurnTotW = FuelW + $clog2(SUM_WINDOW);
  localparam int unsigned DistW = 23;
  localparam int unsigned DistTotW = DistW + $clog2(SUM_WINDOW);
  localparam int unsigned ConsTotW = ConsW + $clog2(MEAN_WINDOW);
  localparam int unsigned ProdW = SpeedW + TimeW;
  localparam int unsigned NumW = BurnTotW + 7;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul = 3'd1;
  localparam logic [2:0] StDivK = 3'd2;
  localparam logic [2:0] StSum = 3'd3;
  localparam logic [2:0] StDivC = 3'd4;
  localparam logic [2:0] StMean = 3'd5;
  localparam logic [2:0] StDivM = 3'd6;
  localparam logic [2:0] StOut = 3'd7;

  logic [OdoW-1:0] odo_q;
  logic [SpeedW-1:0] min_speed_q, fuel_floor_q, dist_floor_q;
  logic [2:0] st_q;
  logic [SpeedW-1:0] mcand_q;
  logic [TimeW-1:0] mplier_q;
  logic [ProdW-1:0] prod_q;
  logic [4:0] mcnt_q;
  logic [FuelW-1:0] last_fuel_q, fuel_q;
  logic [CountW-1:0] tcount_q;
  logic [4:0] tick_rem_q;
  logic [5:0] rem_cnt_q;
  logic [DistW-1:0] dist_q;
  logic [FuelW-1:0] burn_win_q [SUM_WINDOW];
  logic [DistW-1:0] dist_win_q [SUM_WINDOW];
  logic [BurnTotW-1:0] burn_tot_q;
  logic [DistTotW-1:0] dist_tot_q;
  logic [SumIdxW-1:0] sum_slot_q;
  logic [ConsW-1:0] cons_win_q [MEAN_WINDOW];
  logic [ConsTotW-1:0] cons_tot_q;
  logic [MeanIdxW-1:0] mean_slot_q;
  logic [FillW-1:0] fill_q;
  logic [TripW-1:0] trip_q;
  logic [ConsW-1:0] cons_q, avg_q;
  logic out_valid_q;
  logic [TripW-1:0] trip_out_q;
  logic [ConsW-1:0] cons_out_q;

  logic div_start;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic div_done;
  logic [63:0] div_quo;
  logic [TripW:0] trip_sum;
  logic [FuelW-1:0] burned;
  logic [5:0] rem_trial, rem_sub;
  logic refresh_due;
  logic [NumW-1:0] burn_x100;

  assign in_ready_o = (st_q == StIdle);
  assign burned = (last_fuel_q < fuel_q) ? '0 : last_fuel_q - fuel_q;
  assign trip_sum = {1'b0, trip_q} + (TripW+1)'(dist_q);
  assign rem_trial = {tick_rem_q, tcount_q[CountW-1]};
  assign rem_sub = rem_trial - 6'(RefreshPeriod);
  assign refresh_due = (tick_rem_q == '0);
  assign burn_x100 = NumW'({burn_tot_q, 6'd0}) + NumW'({burn_tot_q, 5'd0})
                     + NumW'({burn_tot_q, 2'd0});

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    case (st_q)
      StMul: if (mcnt_q == 5'd0) begin
        div_start = 1'b1;
        div_num = 64'(prod_q);
        div_den = 32'd1000;
      end
      StSum: begin
        div_start = 1'b1;
        div_num = 64'(burn_x100);
        div_den = 32'(dist_tot_q);
      end
      StMean: begin
        div_start = 1'b1;
        div_num = 64'(cons_tot_q);
        div_den = 32'(fill_q);
      end
      default: ;
    endcase
  end

  rfc_divider #(.NumW(64), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odo_q <= '0;
      min_speed_q <= 16'd128;
      fuel_floor_q <= 16'd7;
      dist_floor_q <= 16'd1;
      st_q <= StIdle;
      mcnt_q <= '0;
      tick_rem_q <= '0;
      rem_cnt_q <= '0;
      last_fuel_q <= '0;
      burn_tot_q <= '0;
      dist_tot_q <= '0;
      sum_slot_q <= '0;
      cons_tot_q <= '0;
      mean_slot_q <= '0;
      fill_q <= '0;
      trip_q <= '0;
      avg_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SUM_WINDOW; i++) begin
        burn_win_q[i] <= '0;
        dist_win_q[i] <= '0;
      end
      for (int i = 0; i < MEAN_WINDOW; i++) cons_win_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegOdometer: odo_q <= cfg_data_i;
          RegMinSpeed: min_speed_q <= cfg_data_i[SpeedW-1:0];
          RegFuelFloor: fuel_floor_q <= cfg_data_i[SpeedW-1:0];
          RegDistFloor: dist_floor_q <= cfg_data_i[SpeedW-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        StIdle: if (in_valid_i) begin
          mcand_q <= (speed_i > min_speed_q) ? speed_i : '0;
          mplier_q <= tick_time_ms_i;
          prod_q <= '0;
          mcnt_q <= 5'(TimeW);
          fuel_q <= fuel_level_i;
          tcount_q <= tick_count_i;
          tick_rem_q <= '0;
          rem_cnt_q <= 6'(CountW);
          st_q <= StMul;
        end
        StMul: if (mcnt_q != 5'd0) begin
          if (mplier_q[TimeW-1])
            prod_q <= {prod_q[ProdW-2:0], 1'b0} + ProdW'(mcand_q);
          else
            prod_q <= {prod_q[ProdW-2:0], 1'b0};
          mplier_q <= {mplier_q[TimeW-2:0], 1'b0};
          mcnt_q <= mcnt_q - 1'b1;
        end else begin
          st_q <= StDivK;
        end
        StDivK: if (div_done) begin
          dist_q <= div_quo[DistW-1:0];
          st_q <= StSum;
          burn_tot_q <= burn_tot_q - BurnTotW'(burn_win_q[sum_slot_q])
                        + BurnTotW'(burned);
          dist_tot_q <= dist_tot_q - DistTotW'(dist_win_q[sum_slot_q])
                        + DistTotW'(div_quo[DistW-1:0]);
          burn_win_q[sum_slot_q] <= burned;
          dist_win_q[sum_slot_q] <= div_quo[DistW-1:0];
          sum_slot_q <= (sum_slot_q == SumIdxW'(SUM_WINDOW - 1)) ? '0
                        : sum_slot_q + 1'b1;
          last_fuel_q <= fuel_q;
        end
        StSum: begin
          trip_q <= trip_sum[TripW] ? '1 : trip_sum[TripW-1:0];
          st_q <= StDivC;
        end
        StDivC: if (div_done) begin
          if (burn_tot_q < BurnTotW'(fuel_floor_q)
              || dist_tot_q < DistTotW'(dist_floor_q) || dist_tot_q == '0)
            cons_q <= '0;
          else if (|div_quo[63:ConsW])
            cons_q <= '1;
          else
            cons_q <= div_quo[ConsW-1:0];
          st_q <= StMean;
        end
        StMean: begin
          st_q <= StDivM;
        end
        StDivM: if (div_done && !out_valid_q) begin
          if (refresh_due) avg_q <= div_quo[ConsW-1:0];
          trip_out_q <= trip_q;
          cons_out_q <= cons_q;
          out_valid_q <= 1'b1;
          st_q <= StIdle;
        end else if (div_done) begin
          st_q <= StOut;
          prod_q <= ProdW'(div_quo[ConsW-1:0]);
        end
        StOut: if (!out_valid_q) begin
          if (refresh_due) avg_q <= prod_q[ConsW-1:0];
          trip_out_q <= trip_q;
          cons_out_q <= cons_q;
          out_valid_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
      if (st_q != StIdle && rem_cnt_q != '0) begin
        tick_rem_q <= (rem_trial >= 6'(RefreshPeriod)) ? rem_sub[4:0] : rem_trial[4:0];
        tcount_q <= {tcount_q[CountW-2:0], 1'b0};
        rem_cnt_q <= rem_cnt_q - 1'b1;
      end
      if (st_q == StDivC && div_done) begin
        cons_tot_q <= cons_tot_q - ConsTotW'(cons_win_q[mean_slot_q])
                      + ConsTotW'(
                        (burn_tot_q < BurnTotW'(fuel_floor_q)
                         || dist_tot_q < DistTotW'(dist_floor_q)
                         || dist_tot_q == '0) ? '0
                        : (|div_quo[63:ConsW]) ? {ConsW{1'b1}}
                        : div_quo[ConsW-1:0]);
        cons_win_q[mean_slot_q] <=
          (burn_tot_q < BurnTotW'(fuel_floor_q)
           || dist_tot_q < DistTotW'(dist_floor_q) || dist_tot_q == '0) ? '0
          : (|div_quo[63:ConsW]) ? {ConsW{1'b1}} : div_quo[ConsW-1:0];
        mean_slot_q <= (mean_slot_q == MeanIdxW'(MEAN_WINDOW - 1)) ? '0
                       : mean_slot_q + 1'b1;
        if (fill_q < FillW'(MEAN_WINDOW)) fill_q <= fill_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign trip_distance_o = trip_out_q;
  assign consumption_now_o = cons_out_q;
  assign consumption_average_o = avg_q;
  assign odometer_total_o = odo_q;

  `RFC_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, st_q == StIdle)
  `RFC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `RFC_ASSERT_IMPL(a_fill_range, clk_i, rst_ni, 1'b1, fill_q <= FillW'(MEAN_WINDOW))
endmodule
`default_nettype wire
